// ----- hw/rtl/vproc_pkg.sv -----
// Shared constants for the video processor CPU port: access kinds,
// register indexes, status selects and the reset colour palette.
// Used by video_processor_cpu_port and its checker; depends on nothing.
`timescale 1ns / 1ps

package vproc_pkg;

    // Access kinds carried on the kind field.
    localparam logic [2:0] KIND_DATA_READ  = 3'd0;
    localparam logic [2:0] KIND_DATA_WRITE = 3'd1;
    localparam logic [2:0] KIND_CTRL_WRITE = 3'd2;
    localparam logic [2:0] KIND_STAT_READ  = 3'd3;
    localparam logic [2:0] KIND_PAL_WRITE  = 3'd4;
    localparam logic [2:0] KIND_IND_WRITE  = 3'd5;
    localparam logic [2:0] KIND_LINE_EVENT = 3'd6;

    // Control register indexes with a function in this block.
    localparam int REG_MODE0      = 0;
    localparam int REG_MODE1      = 1;
    localparam int REG_MODE9      = 9;
    localparam int REG_VRAM_HIGH  = 14;
    localparam int REG_STAT_SEL   = 15;
    localparam int REG_PAL_INDEX  = 16;
    localparam int REG_INDIRECT   = 17;
    localparam int REG_LINE_IRQ   = 19;
    localparam int REG_VSCROLL    = 23;
    localparam int NUM_REGS       = 64;

    localparam logic [7:0] MODE1_RESET = 8'h10;

    // Status register selects.
    localparam logic [3:0] STAT_S0 = 4'd0;
    localparam logic [3:0] STAT_S1 = 4'd1;
    localparam logic [3:0] STAT_S2 = 4'd2;

    localparam logic [8:0] HEIGHT_LONG  = 9'd212;
    localparam logic [8:0] HEIGHT_SHORT = 9'd192;

    // Palette entries packed as red, blue, green octal digits.
    localparam int PAL_ENTRIES = 16;
    localparam logic [8:0] DEFAULT_PALETTE [PAL_ENTRIES] = '{
        9'o000, 9'o000, 9'o116, 9'o337, 9'o171, 9'o273, 9'o511, 9'o276,
        9'o711, 9'o733, 9'o616, 9'o646, 9'o114, 9'o652, 9'o555, 9'o777
    };

endpackage

// ----- hw/rtl/video_processor_cpu_port.sv -----
// Top level of the video processor CPU port: register file, status flags,
// latches and the video memory sequencing. Uses vproc_pkg and vproc_ram.
//
//   channel   direction   handshake              payload
//   input     in          in_valid / in_ready    kind, data, line_number
//   output    out         out_valid / out_ready  read_data, interrupt_level
//
// A transaction that reads video memory (a data read, or a control write that
// loads the address with a pre-read) holds the input off while its fetch
// completes, as the single RAM port has a registered read.
// After reset a clearing pass writes zero to every video memory byte, one a
// cycle; no transaction is taken until it ends.
// A registered output stage lets a new transaction in while the previous
// result is being taken; a stalled output holds the input off.
`timescale 1ns / 1ps

module video_processor_cpu_port #(
    parameter int VRAM_BYTES = 131072
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [7:0] data,
    input  logic [8:0] line_number,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data,
    output logic       interrupt_level
);

    localparam int ADDR_W = $clog2(VRAM_BYTES);
    localparam int NREGS  = vproc_pkg::NUM_REGS;
    localparam int NPAL   = vproc_pkg::PAL_ENTRIES;

    logic [7:0]        ctrl_reg [NREGS];
    logic [7:0]        ctrl_next [NREGS];
    logic [8:0]        colour_reg [NPAL];
    logic [8:0]        colour_next [NPAL];
    logic [7:0]        frame_status_reg, frame_status_next;
    logic [7:0]        line_status_reg, line_status_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]        read_ahead_reg, read_ahead_next;
    logic [7:0]        first_byte_reg, first_byte_next;
    logic              first_held_reg, first_held_next;
    logic [7:0]        pal_first_reg, pal_first_next;
    logic              pal_held_reg, pal_held_next;
    logic              blank_reg, blank_next;
    logic              fetch_reg, fetch_next;
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_irq_reg, out_irq_next;

    logic              accept;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic [16:0]       ctl_addr;
    logic [5:0]        ind_idx;
    logic [3:0]        pal_idx;
    logic [8:0]        height;
    logic [7:0]        hit_line;
    logic [7:0]        rd_data;
    logic              irq_next;

    vproc_ram #(
        .WIDTH(8),
        .DEPTH(VRAM_BYTES)
    ) u_vram (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign in_ready = !clearing_reg && !fetch_reg && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign ctl_addr = {ctrl_reg[vproc_pkg::REG_VRAM_HIGH][2:0], data[5:0], first_byte_reg};
    assign ind_idx  = ctrl_reg[vproc_pkg::REG_INDIRECT][5:0];
    assign pal_idx  = ctrl_reg[vproc_pkg::REG_PAL_INDEX][3:0];
    assign height   = ctrl_reg[vproc_pkg::REG_MODE9][7] ? vproc_pkg::HEIGHT_LONG
                                                        : vproc_pkg::HEIGHT_SHORT;
    assign hit_line = ctrl_reg[vproc_pkg::REG_LINE_IRQ] - ctrl_reg[vproc_pkg::REG_VSCROLL];

    always_comb
    begin
        ctrl_next         = ctrl_reg;
        colour_next       = colour_reg;
        frame_status_next = frame_status_reg;
        line_status_next  = line_status_reg;
        addr_next         = addr_reg;
        read_ahead_next   = read_ahead_reg;
        first_byte_next   = first_byte_reg;
        first_held_next   = first_held_reg;
        pal_first_next    = pal_first_reg;
        pal_held_next     = pal_held_reg;
        blank_next        = blank_reg;
        fetch_next        = 1'b0;
        clearing_next     = clearing_reg;
        clear_cnt_next    = clear_cnt_reg;
        ram_we            = 1'b0;
        ram_addr          = addr_reg;
        ram_wdata         = data;
        rd_data           = 8'h00;

        if (clearing_reg)
        begin
            ram_we         = 1'b1;
            ram_addr       = clear_cnt_reg;
            ram_wdata      = 8'h00;
            clear_cnt_next = clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == ADDR_W'(VRAM_BYTES - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        // The byte fetched in the previous cycle lands in the buffer.
        if (fetch_reg)
        begin
            read_ahead_next = ram_rdata;
        end

        if (accept)
        begin
            unique case (kind)
                vproc_pkg::KIND_DATA_READ:
                begin
                    rd_data         = read_ahead_reg;
                    fetch_next      = 1'b1;
                    addr_next       = addr_reg + 1'b1;
                    first_held_next = 1'b0;
                end
                vproc_pkg::KIND_DATA_WRITE:
                begin
                    ram_we          = 1'b1;
                    addr_next       = addr_reg + 1'b1;
                    first_held_next = 1'b0;
                end
                vproc_pkg::KIND_CTRL_WRITE:
                begin
                    if (!first_held_reg)
                    begin
                        first_byte_next = data;
                        first_held_next = 1'b1;
                    end
                    else
                    begin
                        first_held_next = 1'b0;
                        if (data[7])
                        begin
                            ctrl_next[data[5:0]] = first_byte_reg;
                        end
                        else if (data[6])
                        begin
                            addr_next = ctl_addr[ADDR_W-1:0];
                        end
                        else
                        begin
                            ram_addr   = ctl_addr[ADDR_W-1:0];
                            fetch_next = 1'b1;
                            addr_next  = ctl_addr[ADDR_W-1:0] + 1'b1;
                        end
                    end
                end
                vproc_pkg::KIND_STAT_READ:
                begin
                    first_held_next = 1'b0;
                    if (ctrl_reg[vproc_pkg::REG_STAT_SEL][3:0] == vproc_pkg::STAT_S0)
                    begin
                        rd_data           = frame_status_reg;
                        frame_status_next = {3'b000, frame_status_reg[4:0]};
                    end
                    else if (ctrl_reg[vproc_pkg::REG_STAT_SEL][3:0] == vproc_pkg::STAT_S1)
                    begin
                        rd_data          = line_status_reg;
                        line_status_next = {line_status_reg[7:1], 1'b0};
                    end
                    else if (ctrl_reg[vproc_pkg::REG_STAT_SEL][3:0] == vproc_pkg::STAT_S2)
                    begin
                        rd_data = {1'b0, blank_reg, 6'b100000};
                    end
                end
                vproc_pkg::KIND_PAL_WRITE:
                begin
                    if (!pal_held_reg)
                    begin
                        pal_first_next = data;
                        pal_held_next  = 1'b1;
                    end
                    else
                    begin
                        pal_held_next        = 1'b0;
                        colour_next[pal_idx] = {pal_first_reg[6:4], pal_first_reg[2:0],
                                                data[2:0]};
                        ctrl_next[vproc_pkg::REG_PAL_INDEX] = {4'h0, pal_idx + 4'd1};
                    end
                end
                vproc_pkg::KIND_IND_WRITE:
                begin
                    ctrl_next[ind_idx] = data;
                    // The index register may itself have been the target.
                    if (!ctrl_next[vproc_pkg::REG_INDIRECT][7])
                    begin
                        ctrl_next[vproc_pkg::REG_INDIRECT] = {2'b00, ind_idx + 6'd1};
                    end
                end
                vproc_pkg::KIND_LINE_EVENT:
                begin
                    blank_next = (line_number >= height);
                    if (line_number == height)
                    begin
                        frame_status_next[7] = 1'b1;
                    end
                    if (line_number[7:0] == hit_line)
                    begin
                        line_status_next[0] = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        irq_next = (frame_status_next[7] && ctrl_next[vproc_pkg::REG_MODE1][5]) ||
                   (line_status_next[0] && ctrl_next[vproc_pkg::REG_MODE0][4]);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_irq_next   = out_irq_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rd_data;
            out_irq_next   = irq_next;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NREGS; i++)
            begin
                ctrl_reg[i] <= (i == vproc_pkg::REG_MODE1) ? vproc_pkg::MODE1_RESET : 8'h00;
            end
            for (int i = 0; i < NPAL; i++)
            begin
                colour_reg[i] <= vproc_pkg::DEFAULT_PALETTE[i];
            end
            frame_status_reg <= 8'h00;
            line_status_reg  <= 8'h00;
            addr_reg         <= '0;
            read_ahead_reg   <= 8'h00;
            first_byte_reg   <= 8'h00;
            first_held_reg   <= 1'b0;
            pal_first_reg    <= 8'h00;
            pal_held_reg     <= 1'b0;
            blank_reg        <= 1'b0;
            fetch_reg        <= 1'b0;
            clearing_reg     <= 1'b1;
            clear_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= 8'h00;
            out_irq_reg      <= 1'b0;
        end
        else
        begin
            ctrl_reg         <= ctrl_next;
            colour_reg       <= colour_next;
            frame_status_reg <= frame_status_next;
            line_status_reg  <= line_status_next;
            addr_reg         <= addr_next;
            read_ahead_reg   <= read_ahead_next;
            first_byte_reg   <= first_byte_next;
            first_held_reg   <= first_held_next;
            pal_first_reg    <= pal_first_next;
            pal_held_reg     <= pal_held_next;
            blank_reg        <= blank_next;
            fetch_reg        <= fetch_next;
            clearing_reg     <= clearing_next;
            clear_cnt_reg    <= clear_cnt_next;
            out_valid_reg    <= out_valid_next;
            out_data_reg     <= out_data_next;
            out_irq_reg      <= out_irq_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_data_reg;
    assign interrupt_level = out_irq_reg;

endmodule

// ----- hw/rtl/vproc_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// Used for video memory by video_processor_cpu_port; no dependencies.
`timescale 1ns / 1ps

module vproc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hw/rtl/vproc_checker.sv -----
// Port-level checks for video_processor_cpu_port, bound to the top level.
// Depends on vproc_pkg for the access kind codes.
`timescale 1ns / 1ps

module vproc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] read_data,
    input logic       interrupt_level
);

    // A stalled result holds its value until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(interrupt_level))
        else $error("result changed while stalled");

    // A data read fetches memory, so the next cycle takes no transaction.
    a_fetch_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind == vproc_pkg::KIND_DATA_READ |=> !in_ready)
        else $error("transaction taken during memory fetch");

    // Only data and status reads return a non-zero byte.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && kind != vproc_pkg::KIND_DATA_READ &&
        kind != vproc_pkg::KIND_STAT_READ |=> out_valid && read_data == 8'h00)
        else $error("non-read transaction returned data");

    // Input is only taken when the output stage has room.
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("input taken with the output stage full");

endmodule

bind video_processor_cpu_port vproc_checker u_vproc_checker (.*);

// ----- tb/tb_video_processor_cpu_port.sv -----
// Self-checking testbench for video_processor_cpu_port: directed and random port
// accesses are checked against a cycle-free predictor of the register, latch and flag logic.
// Depends on vproc_pkg and the video_processor_cpu_port RTL.
`timescale 1ns / 1ps

module tb_video_processor_cpu_port;

    localparam int VRAM_BYTES = 131072;
    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int REG_CMD_COLOUR = 44;
    localparam int REG_CMD_OP = 46;
    localparam int RANDOM_ITEMS = 1900;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PERCENT = 21;
    localparam int STALL_AT = 700;
    localparam int STALL_CYCLES = 400;
    localparam int CALM_FROM = 1100;
    localparam int CALM_TO = 1400;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [8:0] line_number;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt_level;
    } response_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] kind = '0;
    logic [7:0] data = '0;
    logic [8:0] line_number = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] read_data;
    logic       interrupt_level;

    video_processor_cpu_port #(
        .VRAM_BYTES(VRAM_BYTES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .data(data),
        .line_number(line_number),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .interrupt_level(interrupt_level)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the port state.
    logic [7:0]  shadow_vram [VRAM_BYTES];
    logic [7:0]  shadow_regs [vproc_pkg::NUM_REGS];
    logic [8:0]  shadow_palette [vproc_pkg::PAL_ENTRIES];
    logic [7:0]  shadow_s0;
    logic [7:0]  shadow_s1;
    logic [16:0] shadow_addr;
    logic [7:0]  shadow_prefetch;
    logic [7:0]  shadow_ctrl_byte;
    logic        shadow_ctrl_half;
    logic [7:0]  shadow_pal_byte;
    logic        shadow_pal_half;
    logic        shadow_blank;

    access_t   pending_accesses[$];
    response_t expected_responses[$];
    logic      gen_ctrl_half = 1'b0;
    int        failures = 0;
    int        cycle_count = 0;
    int        responses_seen = 0;
    logic      in_taken = 1'b0;
    int        stall_left = 0;
    logic      stall_done = 1'b0;
    logic      calm;

    assign calm = (responses_seen >= CALM_FROM) && (responses_seen < CALM_TO);

    function automatic logic irq_level();
        return (shadow_s0[7] && shadow_regs[vproc_pkg::REG_MODE1][5]) ||
               (shadow_s1[0] && shadow_regs[vproc_pkg::REG_MODE0][4]);
    endfunction

    task automatic compute_port_response(input access_t acc, output response_t resp);
        logic [7:0] rd;
        logic [5:0] idx;
        logic [3:0] pidx;
        logic [8:0] height;
        logic [7:0] hit;
        rd = '0;
        case (acc.kind)
            vproc_pkg::KIND_DATA_READ:
            begin
                rd = shadow_prefetch;
                shadow_prefetch = shadow_vram[shadow_addr];
                shadow_addr = shadow_addr + 17'd1;
                shadow_ctrl_half = 1'b0;
            end
            vproc_pkg::KIND_DATA_WRITE:
            begin
                shadow_vram[shadow_addr] = acc.data;
                shadow_addr = shadow_addr + 17'd1;
                shadow_ctrl_half = 1'b0;
            end
            vproc_pkg::KIND_CTRL_WRITE:
            begin
                if (!shadow_ctrl_half)
                begin
                    shadow_ctrl_byte = acc.data;
                    shadow_ctrl_half = 1'b1;
                end
                else
                begin
                    shadow_ctrl_half = 1'b0;
                    if (acc.data[7])
                        shadow_regs[acc.data[5:0]] = shadow_ctrl_byte;
                    else
                    begin
                        shadow_addr = {shadow_regs[vproc_pkg::REG_VRAM_HIGH][2:0],
                                       acc.data[5:0], shadow_ctrl_byte};
                        if (!acc.data[6])
                        begin
                            shadow_prefetch = shadow_vram[shadow_addr];
                            shadow_addr = shadow_addr + 17'd1;
                        end
                    end
                end
            end
            vproc_pkg::KIND_STAT_READ:
            begin
                case (shadow_regs[vproc_pkg::REG_STAT_SEL][3:0])
                    vproc_pkg::STAT_S0:
                    begin
                        rd = shadow_s0;
                        shadow_s0 = shadow_s0 & 8'h1f;
                    end
                    vproc_pkg::STAT_S1:
                    begin
                        rd = shadow_s1;
                        shadow_s1[0] = 1'b0;
                    end
                    vproc_pkg::STAT_S2: rd = {1'b0, shadow_blank, 1'b1, 5'b0};
                    default: rd = '0;
                endcase
                shadow_ctrl_half = 1'b0;
            end
            vproc_pkg::KIND_PAL_WRITE:
            begin
                if (!shadow_pal_half)
                begin
                    shadow_pal_byte = acc.data;
                    shadow_pal_half = 1'b1;
                end
                else
                begin
                    shadow_pal_half = 1'b0;
                    pidx = shadow_regs[vproc_pkg::REG_PAL_INDEX][3:0];
                    shadow_palette[pidx] = {shadow_pal_byte[6:4], shadow_pal_byte[2:0],
                                            acc.data[2:0]};
                    shadow_regs[vproc_pkg::REG_PAL_INDEX] = {4'b0, pidx + 4'd1};
                end
            end
            vproc_pkg::KIND_IND_WRITE:
            begin
                idx = shadow_regs[vproc_pkg::REG_INDIRECT][5:0];
                shadow_regs[idx] = acc.data;
                // The index register may just have been overwritten, so test it afresh.
                if (!shadow_regs[vproc_pkg::REG_INDIRECT][7])
                    shadow_regs[vproc_pkg::REG_INDIRECT] = {2'b0, idx + 6'd1};
            end
            vproc_pkg::KIND_LINE_EVENT:
            begin
                height = shadow_regs[vproc_pkg::REG_MODE9][7] ? vproc_pkg::HEIGHT_LONG
                                                              : vproc_pkg::HEIGHT_SHORT;
                hit = shadow_regs[vproc_pkg::REG_LINE_IRQ] - shadow_regs[vproc_pkg::REG_VSCROLL];
                shadow_blank = (acc.line_number >= height);
                if (acc.line_number == height)
                    shadow_s0[7] = 1'b1;
                if (acc.line_number[7:0] == hit)
                    shadow_s1[0] = 1'b1;
            end
            default: ;
        endcase
        resp.read_data = rd;
        resp.interrupt_level = irq_level();
    endtask

    // Stimulus building; the control latch phase is tracked so that pairs stay aligned.
    task automatic push_access(input logic [2:0] k, input logic [7:0] d, input logic [8:0] ln);
        access_t acc;
        acc.kind = k;
        acc.data = d;
        acc.line_number = ln;
        pending_accesses.push_back(acc);
        if (k == vproc_pkg::KIND_CTRL_WRITE)
            gen_ctrl_half = !gen_ctrl_half;
        else if (k == vproc_pkg::KIND_DATA_READ || k == vproc_pkg::KIND_DATA_WRITE ||
                 k == vproc_pkg::KIND_STAT_READ)
            gen_ctrl_half = 1'b0;
    endtask

    task automatic push_ctrl_pair(input logic [7:0] first, input logic [7:0] second);
        if (gen_ctrl_half)
            push_access(vproc_pkg::KIND_STAT_READ, 8'($urandom_range(255)),
                        9'($urandom_range(511)));
        push_access(vproc_pkg::KIND_CTRL_WRITE, first, 9'($urandom_range(511)));
        push_access(vproc_pkg::KIND_CTRL_WRITE, second, 9'($urandom_range(511)));
    endtask

    task automatic push_reg_write(input int idx, input logic [7:0] value);
        push_ctrl_pair(value, {2'b10, idx[5:0]});
    endtask

    always @(posedge clk)
    begin : monitor
        access_t   seen;
        response_t predicted;
        response_t wanted;
        cycle_count <= cycle_count + 1;
        in_taken <= in_valid && in_ready;
        if (rst_n && out_valid && out_ready)
        begin
            responses_seen <= responses_seen + 1;
            if (expected_responses.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected transaction: expected none, actual %02h %b",
                         $time, read_data, interrupt_level);
            end
            else
            begin
                wanted = expected_responses.pop_front();
                if (read_data !== wanted.read_data)
                begin
                    failures++;
                    $display("%0t: read_data mismatch: expected %02h, actual %02h",
                             $time, wanted.read_data, read_data);
                end
                if (interrupt_level !== wanted.interrupt_level)
                begin
                    failures++;
                    $display("%0t: interrupt_level mismatch: expected %b, actual %b",
                             $time, wanted.interrupt_level, interrupt_level);
                end
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            seen = {kind, data, line_number};
            compute_port_response(seen, predicted);
            expected_responses.push_back(predicted);
        end
    end

    always @(negedge clk)
    begin : driver
        access_t next;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_accesses.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                next = pending_accesses.pop_front();
                kind <= next.kind;
                data <= next.data;
                line_number <= next.line_number;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // One long hold-off lets the output stage fill and push back on the input.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!stall_done && responses_seen >= STALL_AT)
        begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int       target;
        int       choice;
        int       n;
        logic     writing;
        logic [7:0] lo;
        logic [5:0] hi;
        logic [7:0] v19;
        logic [7:0] v23;
        logic [8:0] ln;
        int       watched_regs [11];

        watched_regs = '{vproc_pkg::REG_MODE0, vproc_pkg::REG_MODE1, vproc_pkg::REG_MODE9,
                         vproc_pkg::REG_VRAM_HIGH, vproc_pkg::REG_STAT_SEL,
                         vproc_pkg::REG_PAL_INDEX, vproc_pkg::REG_INDIRECT,
                         vproc_pkg::REG_LINE_IRQ, vproc_pkg::REG_VSCROLL,
                         REG_CMD_COLOUR, REG_CMD_OP};

        foreach (shadow_vram[i])
            shadow_vram[i] = '0;
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_regs[vproc_pkg::REG_MODE1] = vproc_pkg::MODE1_RESET;
        for (int i = 0; i < vproc_pkg::PAL_ENTRIES; i++)
            shadow_palette[i] = vproc_pkg::DEFAULT_PALETTE[i];
        shadow_s0 = '0;
        shadow_s1 = '0;
        shadow_addr = '0;
        shadow_prefetch = '0;
        shadow_ctrl_byte = '0;
        shadow_ctrl_half = 1'b0;
        shadow_pal_byte = '0;
        shadow_pal_half = 1'b0;
        shadow_blank = 1'b0;

        // Directed opening: reset values, the unused kind, address wrap at the top of
        // memory, the frame flag, a line hit through bit 8 and clear-on-read status.
        push_access(vproc_pkg::KIND_STAT_READ, 8'h00, 9'h000);
        push_access(KIND_UNUSED, 8'hff, 9'h1ff);
        push_access(vproc_pkg::KIND_DATA_READ, 8'h00, 9'h000);
        push_reg_write(vproc_pkg::REG_MODE1, 8'h60);
        push_reg_write(vproc_pkg::REG_MODE0, 8'h10);
        push_reg_write(vproc_pkg::REG_VRAM_HIGH, 8'h07);
        push_ctrl_pair(8'hff, 8'h7f);
        push_access(vproc_pkg::KIND_DATA_WRITE, 8'hff, 9'h1ff);
        push_access(vproc_pkg::KIND_DATA_WRITE, 8'h00, 9'h000);
        push_ctrl_pair(8'hff, 8'h3f);
        push_access(vproc_pkg::KIND_DATA_READ, 8'hff, 9'h1ff);
        push_access(vproc_pkg::KIND_LINE_EVENT, 8'h00, vproc_pkg::HEIGHT_SHORT);
        push_access(vproc_pkg::KIND_LINE_EVENT, 8'hff, 9'h100);
        push_access(vproc_pkg::KIND_STAT_READ, 8'h00, 9'h000);
        push_reg_write(vproc_pkg::REG_STAT_SEL, 8'h01);
        push_access(vproc_pkg::KIND_STAT_READ, 8'hff, 9'h1ff);
        push_access(vproc_pkg::KIND_PAL_WRITE, 8'h77, 9'h000);
        push_access(vproc_pkg::KIND_PAL_WRITE, 8'h07, 9'h000);
        push_access(vproc_pkg::KIND_IND_WRITE, 8'h00, 9'h000);

        target = pending_accesses.size() + RANDOM_ITEMS;
        while (pending_accesses.size() < target)
        begin
            choice = $urandom_range(99);
            if (choice < 15)
            begin
                n = ($urandom_range(1) == 1) ? watched_regs[$urandom_range(10)]
                                             : $urandom_range(vproc_pkg::NUM_REGS - 1);
                if (n == vproc_pkg::REG_STAT_SEL && $urandom_range(9) < 7)
                    push_reg_write(n, 8'($urandom_range(2)));
                else
                    push_reg_write(n, 8'($urandom_range(255)));
            end
            else if (choice < 35)
            begin
                if ($urandom_range(9) < 3)
                    push_reg_write(vproc_pkg::REG_VRAM_HIGH,
                                   ($urandom_range(9) < 5) ? 8'h00 : 8'($urandom_range(255)));
                lo = 8'($urandom_range(255));
                hi = ($urandom_range(1) == 1) ? 6'($urandom_range(3)) : 6'($urandom_range(63));
                if ($urandom_range(9) == 0)
                begin
                    // Near the top of the bank so that bursts run across the bank boundary.
                    lo = 8'hff - 8'($urandom_range(3));
                    hi = 6'h3f;
                end
                push_ctrl_pair(lo, {1'b0, 1'($urandom_range(1)), hi});
                n = $urandom_range(1, 8);
                writing = 1'($urandom_range(1));
                repeat (n)
                    push_access((writing ^ ($urandom_range(9) == 0)) ? vproc_pkg::KIND_DATA_WRITE
                                                                     : vproc_pkg::KIND_DATA_READ,
                                8'($urandom_range(255)), 9'($urandom_range(511)));
            end
            else if (choice < 45)
            begin
                if ($urandom_range(9) < 4)
                    push_reg_write(vproc_pkg::REG_STAT_SEL,
                                   ($urandom_range(9) < 8) ? 8'($urandom_range(2))
                                                           : 8'($urandom_range(255)));
                repeat ($urandom_range(1, 2))
                    push_access(vproc_pkg::KIND_STAT_READ, 8'($urandom_range(255)),
                                9'($urandom_range(511)));
            end
            else if (choice < 55)
            begin
                if ($urandom_range(9) < 3)
                    push_reg_write(vproc_pkg::REG_PAL_INDEX, 8'($urandom_range(255)));
                repeat ($urandom_range(2, 3))
                    push_access(vproc_pkg::KIND_PAL_WRITE, 8'($urandom_range(255)),
                                9'($urandom_range(511)));
            end
            else if (choice < 65)
            begin
                push_reg_write(vproc_pkg::REG_INDIRECT, 8'($urandom_range(255)));
                repeat ($urandom_range(1, 4))
                    push_access(vproc_pkg::KIND_IND_WRITE, 8'($urandom_range(255)),
                                9'($urandom_range(511)));
            end
            else if (choice < 85)
            begin
                if ($urandom_range(1) == 1)
                begin
                    v19 = 8'($urandom_range(255));
                    v23 = 8'($urandom_range(255));
                    push_reg_write(vproc_pkg::REG_LINE_IRQ, v19);
                    push_reg_write(vproc_pkg::REG_VSCROLL, v23);
                    ln = {1'($urandom_range(1)), 8'(v19 - v23)};
                end
                else
                begin
                    if ($urandom_range(9) < 3)
                        push_reg_write(vproc_pkg::REG_MODE9, 8'($urandom_range(255)));
                    case ($urandom_range(3))
                        0: ln = 9'(vproc_pkg::HEIGHT_SHORT + $urandom_range(2) - 1);
                        1: ln = 9'(vproc_pkg::HEIGHT_LONG + $urandom_range(2) - 1);
                        default: ln = 9'($urandom_range(511));
                    endcase
                end
                push_access(vproc_pkg::KIND_LINE_EVENT, 8'($urandom_range(255)), ln);
                if ($urandom_range(9) < 4)
                    push_access(vproc_pkg::KIND_STAT_READ, 8'($urandom_range(255)),
                                9'($urandom_range(511)));
            end
            else
                push_access(3'($urandom_range(7)), 8'($urandom_range(255)),
                            9'($urandom_range(511)));
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_accesses.size() == 0 && !in_valid);
        wait (expected_responses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/vproc_pkg.sv
hw/rtl/vproc_ram.sv
hw/rtl/video_processor_cpu_port.sv
hw/rtl/vproc_checker.sv
tb/tb_video_processor_cpu_port.sv
